// File: hdl/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types, constants and arithmetic helpers for the barometer
// temperature/pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int ADC_W    = 20;
  localparam int ADC_BITS = 20;
  localparam logic [ADC_W-1:0] ADC_KEEP =
    ADC_W'(((1 << ADC_W) - 1) & ~((1 << (ADC_W - ADC_BITS)) - 1));

  localparam int TEMP_STAGES = 5;
  localparam int PRE_STAGES  = 5;
  localparam int DIV_STEPS   = 2;
  localparam int DIV_STAGES  = 64 / DIV_STEPS;
  localparam int POST_STAGES = 5;
  localparam int LATENCY     = TEMP_STAGES + PRE_STAGES + 1 + DIV_STAGES + POST_STAGES;

  typedef enum logic [1:0] {
    CFG_TEMP    = 2'd0,
    CFG_PRESS_A = 2'd1,
    CFG_PRESS_B = 2'd2,
    CFG_PRESS_C = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // temperature stage -> pressure front end
  typedef struct packed {
    logic              vld;
    logic [31:0]       temp_centi;
    logic [31:0]       fine;
    logic signed [32:0] x1;
    logic [ADC_W-1:0]  adc_press;
  } tp_t;

  // pressure front end -> divider
  typedef struct packed {
    logic        vld;
    logic [31:0] temp_centi;
    logic [31:0] fine;
    logic        invalid;
    logic [63:0] num;
    logic [63:0] den;
  } div_in_t;

  // divider -> pressure back end
  typedef struct packed {
    logic        vld;
    logic [31:0] temp_centi;
    logic [31:0] fine;
    logic        invalid;
    logic        neg;
    logic [63:0] quo;
  } div_out_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] temp_centi;
    logic [31:0] fine;
    logic [31:0] press;
    logic        invalid;
  } res_t;

  function automatic logic signed [16:0] sx17(input logic signed [15:0] v);
    return $signed({v[15], v});
  endfunction

  // low 64 bits of a 64-bit word times a 17-bit signed value, two partial products
  function automatic logic [63:0] mul64s17(input logic [63:0] a,
                                           input logic signed [16:0] s);
    logic signed [49:0] lo;
    logic signed [48:0] hi;
    lo = $signed({1'b0, a[31:0]}) * s;
    hi = $signed(a[63:32]) * s;
    return 64'(lo) + {hi[31:0], 32'd0};
  endfunction

endpackage

// File: hdl/bptc_temp.sv
// ----------------------------------------------------------------------------
// bptc_temp
// Temperature compensation pipeline, 32-bit wrapping arithmetic, five stages.
// ----------------------------------------------------------------------------
module bptc_temp import bptc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [ADC_W-1:0] adc_temp,
  input  logic [ADC_W-1:0] adc_press,
  input  cal_t             cal,
  output tp_t              tp
);

  typedef struct packed {
    logic             vld;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [ADC_W-1:0] ap;
  } st_t;

  st_t s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt, s4_r, s4_nxt;
  tp_t s5_r, s5_nxt;

  logic [ADC_W-1:0] at;
  logic [31:0]      t2x, t3x, f5;

  always_comb begin
    at  = adc_temp & ADC_KEEP;
    t2x = 32'(cal.t2);
    t3x = 32'(cal.t3);

    s1_nxt.vld = in_vld;
    s1_nxt.a   = {15'd0, at[19:3]} - {15'd0, cal.t1, 1'b0};
    s1_nxt.b   = {16'd0, at[19:4]} - {16'd0, cal.t1};
    s1_nxt.ap  = adc_press & ADC_KEEP;

    s2_nxt     = s1_r;
    s2_nxt.a   = s1_r.a * t2x;
    s2_nxt.b   = s1_r.b * s1_r.b;

    s3_nxt     = s2_r;
    s3_nxt.a   = 32'($signed(s2_r.a) >>> 11);
    s3_nxt.b   = 32'($signed(s2_r.b) >>> 12) * t3x;

    s4_nxt     = s3_r;
    s4_nxt.a   = s3_r.a + 32'($signed(s3_r.b) >>> 14);

    f5                = (s4_r.a << 2) + s4_r.a + 32'd128;
    s5_nxt.vld        = s4_r.vld;
    s5_nxt.fine       = s4_r.a;
    s5_nxt.temp_centi = 32'($signed(f5) >>> 8);
    s5_nxt.x1         = $signed({s4_r.a[31], s4_r.a} - 33'd128000);
    s5_nxt.adc_press  = s4_r.ap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      s3_r.vld <= 1'b0;
      s4_r.vld <= 1'b0;
      s5_r.vld <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
    end
  end

  assign tp = s5_r;

endmodule

// File: hdl/bptc_press_pre.sv
// ----------------------------------------------------------------------------
// bptc_press_pre
// Pressure front end: builds dividend and divisor, 64-bit wrapping, five stages.
// ----------------------------------------------------------------------------
module bptc_press_pre import bptc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  tp_t     tp,
  input  cal_t    cal,
  output div_in_t dv
);

  typedef struct packed {
    logic             vld;
    logic [31:0]      temp_centi;
    logic [31:0]      fine;
    logic [ADC_W-1:0] ap;
    logic [63:0]      a;
    logic [63:0]      b;
    logic [63:0]      c;
    logic [63:0]      d;
  } st_t;

  st_t q1_r, q1_nxt, q2_r, q2_nxt, q3_r, q3_nxt, q4_r, q4_nxt;
  div_in_t q5_r, q5_nxt;

  logic signed [63:0] xx, x1p5, x1p2;
  logic [20:0]        pr;
  logic [63:0]        w1;

  always_comb begin
    xx   = tp.x1 * tp.x1;
    x1p5 = tp.x1 * cal.p5;
    x1p2 = tp.x1 * cal.p2;

    q1_nxt.vld        = tp.vld;
    q1_nxt.temp_centi = tp.temp_centi;
    q1_nxt.fine       = tp.fine;
    q1_nxt.ap         = tp.adc_press;
    q1_nxt.a          = xx;
    q1_nxt.b          = x1p5;
    q1_nxt.c          = x1p2;
    q1_nxt.d          = '0;

    q2_nxt   = q1_r;
    q2_nxt.a = mul64s17(q1_r.a, sx17(cal.p6));
    q2_nxt.d = mul64s17(q1_r.a, sx17(cal.p3));

    q3_nxt   = q2_r;
    q3_nxt.a = q2_r.a + (q2_r.b << 17) + (64'(cal.p4) << 35);
    q3_nxt.d = 64'($signed(q2_r.d) >>> 8) + (q2_r.c << 12) + (64'd1 << 47);

    pr       = 21'd1048576 - {1'b0, q3_r.ap};
    q4_nxt   = q3_r;
    q4_nxt.d = mul64s17(q3_r.d, $signed({1'b0, cal.p1}));
    q4_nxt.a = ({43'd0, pr} << 31) - q3_r.a;

    w1                = 64'($signed(q4_r.d) >>> 33);
    q5_nxt.vld        = q4_r.vld;
    q5_nxt.temp_centi = q4_r.temp_centi;
    q5_nxt.fine       = q4_r.fine;
    q5_nxt.invalid    = (w1 == 64'd0);
    q5_nxt.num        = mul64s17(q4_r.a, 17'sd3125);
    q5_nxt.den        = w1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_r.vld <= 1'b0;
      q2_r.vld <= 1'b0;
      q3_r.vld <= 1'b0;
      q4_r.vld <= 1'b0;
      q5_r.vld <= 1'b0;
    end else begin
      q1_r <= q1_nxt;
      q2_r <= q2_nxt;
      q3_r <= q3_nxt;
      q4_r <= q4_nxt;
      q5_r <= q5_nxt;
    end
  end

  assign dv = q5_r;

endmodule

// File: hdl/bptc_div.sv
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined signed 64/32 restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module bptc_div import bptc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_in_t  dv,
  output div_out_t dq
);

  typedef struct packed {
    logic        vld;
    logic [31:0] temp_centi;
    logic [31:0] fine;
    logic        invalid;
    logic        neg;
    logic [31:0] rem;
    logic [63:0] nq;
    logic [31:0] md;
  } st_t;

  st_t st_r [0:DIV_STAGES];
  st_t st0_nxt;
  logic [63:0] mn, mdf;

  always_comb begin
    mn  = dv.num[63] ? (64'd0 - dv.num) : dv.num;
    mdf = dv.den[63] ? (64'd0 - dv.den) : dv.den;
    st0_nxt.vld        = dv.vld;
    st0_nxt.temp_centi = dv.temp_centi;
    st0_nxt.fine       = dv.fine;
    st0_nxt.invalid    = dv.invalid;
    st0_nxt.neg        = dv.num[63] ^ dv.den[63];
    st0_nxt.rem        = '0;
    st0_nxt.nq         = mn;
    st0_nxt.md         = mdf[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].vld <= 1'b0;
    end else begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    st_t         nxt;
    logic [32:0] r2;

    always_comb begin
      nxt = st_r[k];
      r2  = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        r2     = {nxt.rem, nxt.nq[63]};
        nxt.nq = nxt.nq << 1;
        if (r2 >= {1'b0, nxt.md}) begin
          r2        = r2 - {1'b0, nxt.md};
          nxt.nq[0] = 1'b1;
        end
        nxt.rem = r2[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k+1].vld <= 1'b0;
      end else begin
        st_r[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    dq.vld        = st_r[DIV_STAGES].vld;
    dq.temp_centi = st_r[DIV_STAGES].temp_centi;
    dq.fine       = st_r[DIV_STAGES].fine;
    dq.invalid    = st_r[DIV_STAGES].invalid;
    dq.neg        = st_r[DIV_STAGES].neg;
    dq.quo        = st_r[DIV_STAGES].nq;
  end

endmodule

// File: hdl/bptc_press_post.sv
// ----------------------------------------------------------------------------
// bptc_press_post
// Pressure back end: quotient sign, P7..P9 corrections, output register.
// ----------------------------------------------------------------------------
module bptc_press_post import bptc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_out_t dq,
  input  cal_t     cal,
  output res_t     res
);

  typedef struct packed {
    logic        vld;
    logic [31:0] temp_centi;
    logic [31:0] fine;
    logic        invalid;
    logic [63:0] p;
    logic [63:0] ps;
    logic [63:0] b;
    logic [63:0] c;
    logic [31:0] lh;
    logic [31:0] hl;
  } st_t;

  st_t  r1_r, r1_nxt, r2_r, r2_nxt, r3_r, r3_nxt, r4_r, r4_nxt;
  res_t r5_r, r5_nxt;

  logic [63:0] prod, rsum;

  always_comb begin
    r1_nxt            = '0;
    r1_nxt.vld        = dq.vld;
    r1_nxt.temp_centi = dq.temp_centi;
    r1_nxt.fine       = dq.fine;
    r1_nxt.invalid    = dq.invalid;
    r1_nxt.p          = dq.neg ? (64'd0 - dq.quo) : dq.quo;

    r2_nxt    = r1_r;
    r2_nxt.ps = 64'($signed(r1_r.p) >>> 13);
    r2_nxt.b  = mul64s17(64'($signed(r1_r.p) >>> 13), sx17(cal.p9));
    r2_nxt.c  = mul64s17(r1_r.p, sx17(cal.p8));

    // b * ps low 64 bits: ll in b, cross terms in lh/hl
    r3_nxt    = r2_r;
    r3_nxt.b  = r2_r.b[31:0] * r2_r.ps[31:0];
    r3_nxt.lh = r2_r.b[31:0] * r2_r.ps[63:32];
    r3_nxt.hl = r2_r.b[63:32] * r2_r.ps[31:0];
    r3_nxt.c  = 64'($signed(r2_r.c) >>> 19);

    prod     = r3_r.b + {r3_r.lh + r3_r.hl, 32'd0};
    r4_nxt   = r3_r;
    r4_nxt.p = r3_r.p + 64'($signed(prod) >>> 25) + r3_r.c;

    rsum              = 64'($signed(r4_r.p) >>> 8) + (64'(cal.p7) << 4);
    r5_nxt.vld        = r4_r.vld;
    r5_nxt.temp_centi = r4_r.temp_centi;
    r5_nxt.fine       = r4_r.fine;
    r5_nxt.invalid    = r4_r.invalid;
    r5_nxt.press      = r4_r.invalid ? 32'd0 : rsum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_r.vld <= 1'b0;
      r2_r.vld <= 1'b0;
      r3_r.vld <= 1'b0;
      r4_r.vld <= 1'b0;
      r5_r.vld <= 1'b0;
    end else begin
      r1_r <= r1_nxt;
      r2_r <= r2_nxt;
      r3_r <= r3_nxt;
      r4_r <= r4_nxt;
      r5_r <= r5_nxt;
    end
  end

  assign res = r5_r;

endmodule

// File: hdl/baro_temp_press_compensate_top.sv
// ----------------------------------------------------------------------------
// baro_temp_press_compensate_top
// Barometer temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Load calibration through the cfg_ channel (cfg_valid/cfg_ready, index,
//   64-bit data); cfg_ready is always high. Write only while no transaction
//   is in flight.
//   A sample pair is taken on any edge with start high and busy low; busy is
//   always low, so one transaction per clock is accepted.
//   Each transaction yields one result on the out_ ports, marked by a single
//   cycle out_valid strobe, once it has passed through 5 temperature stages,
//   5 pressure front-end stages, 33 divider stages and 5 back-end stages.
//   Throughput is one transaction per cycle, set by the divider pipeline,
//   which resolves two quotient bits per stage.
//   Results are in acceptance order. The receiver cannot stall; every strobe
//   must be taken.
//   Reset (rst_n low, synchronous) clears all in-flight transactions and sets
//   every calibration word to zero.
// ----------------------------------------------------------------------------
module baro_temp_press_compensate_top import bptc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [ADC_W-1:0] in_adc_temp,
  input  logic [ADC_W-1:0] in_adc_press,
  output logic             out_valid,
  output logic [31:0]      out_temp_centi,
  output logic [31:0]      out_fine_temp,
  output logic [31:0]      out_press_q24_8,
  output logic             out_press_invalid,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data
);

  cal_t    cal_r;
  tp_t     tp;
  div_in_t dv;
  div_out_t dq;
  res_t    res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP: begin
          cal_r.t1 <= cfg_data[15:0];
          cal_r.t2 <= cfg_data[31:16];
          cal_r.t3 <= cfg_data[47:32];
        end
        CFG_PRESS_A: begin
          cal_r.p1 <= cfg_data[15:0];
          cal_r.p2 <= cfg_data[31:16];
          cal_r.p3 <= cfg_data[47:32];
          cal_r.p4 <= cfg_data[63:48];
        end
        CFG_PRESS_B: begin
          cal_r.p5 <= cfg_data[15:0];
          cal_r.p6 <= cfg_data[31:16];
          cal_r.p7 <= cfg_data[47:32];
          cal_r.p8 <= cfg_data[63:48];
        end
        CFG_PRESS_C: begin
          cal_r.p9 <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  bptc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start && !busy),
    .adc_temp  (in_adc_temp),
    .adc_press (in_adc_press),
    .cal       (cal_r),
    .tp        (tp)
  );

  bptc_press_pre u_pre (
    .clk   (clk),
    .rst_n (rst_n),
    .tp    (tp),
    .cal   (cal_r),
    .dv    (dv)
  );

  bptc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .dv    (dv),
    .dq    (dq)
  );

  bptc_press_post u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .dq    (dq),
    .cal   (cal_r),
    .res   (res)
  );

  assign out_valid         = res.vld;
  assign out_temp_centi    = res.temp_centi;
  assign out_fine_temp     = res.fine;
  assign out_press_q24_8   = res.press;
  assign out_press_invalid = res.invalid;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without matching transaction");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_press_invalid |-> out_press_q24_8 == 32'd0)
    else $error("invalid pressure not forced to zero");

  a_div_lat: assert property (@(posedge clk) disable iff (!rst_n)
    dq.vld |-> $past(dv.vld, DIV_STAGES + 1))
    else $error("divider valid lost alignment");

endmodule

// File: verif/tb_baro_temp_press_compensate_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_baro_temp_press_compensate_top
// Drives raw temperature/pressure pairs under several calibration sets and
// checks temperature, fine temperature, pressure and the invalid flag of each
// result against a bit-accurate in-bench compensation model, in order.
// ----------------------------------------------------------------------------
module tb_baro_temp_press_compensate_top;
  import bptc_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] fine_temp;
    logic [31:0] press;
    logic        invalid;
  } comp_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [ADC_W-1:0] in_adc_temp = '0;
  logic [ADC_W-1:0] in_adc_press = '0;
  logic             out_valid;
  logic [31:0]      out_temp_centi;
  logic [31:0]      out_fine_temp;
  logic [31:0]      out_press_q24_8;
  logic             out_press_invalid;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [63:0]      cfg_data = '0;

  logic [47:0] cal_temp;
  logic [63:0] cal_press_a, cal_press_b;
  logic [15:0] cal_press_c;

  comp_res_t   comp_queue[$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          idle_pct = 0;

  baro_temp_press_compensate_top u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] sx64(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic comp_res_t compensate(input logic [19:0] at_raw, input logic [19:0] ap_raw);
    comp_res_t r;
    logic signed [31:0] at, t1, t2, t3, a, v1, d, v2, fine, temp;
    logic signed [63:0] x1, w1, w2, p, p1, p2, p3, p4, p5, p6, p7, p8, p9, n;
    logic [63:0] mn, md, q;
    at = {12'd0, at_raw & ADC_KEEP};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    a = (at >>> 3) - (t1 <<< 1);
    v1 = (a * t2) >>> 11;
    d = (at >>> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    fine = v1 + v2;
    temp = (fine * 32'sd5 + 32'sd128) >>> 8;
    p1 = {48'd0, cal_press_a[15:0]};
    p2 = sx64(cal_press_a[31:16]);
    p3 = sx64(cal_press_a[47:32]);
    p4 = sx64(cal_press_a[63:48]);
    p5 = sx64(cal_press_b[15:0]);
    p6 = sx64(cal_press_b[31:16]);
    p7 = sx64(cal_press_b[47:32]);
    p8 = sx64(cal_press_b[63:48]);
    p9 = sx64(cal_press_c);
    x1 = {{32{fine[31]}}, fine} - 64'sd128000;
    w2 = x1 * x1 * p6;
    w2 = w2 + ((x1 * p5) <<< 17);
    w2 = w2 + (p4 <<< 35);
    w1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) <<< 12);
    w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
    r.temp_centi = temp;
    r.fine_temp  = fine;
    r.press      = '0;
    r.invalid    = (w1 == 0);
    if (w1 != 0) begin
      p = 64'sd1048576 - $signed({44'd0, ap_raw & ADC_KEEP});
      n = ((p <<< 31) - w2) * 64'sd3125;
      mn = n[63] ? -n : n;
      md = w1[63] ? -w1 : w1;
      q = mn / md;
      p = (n[63] != w1[63]) ? -q : q;
      x1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + x1 + w2) >>> 8) + (p7 <<< 4);
      r.press = p[31:0];
    end
    return r;
  endfunction

  // calibration mirror, input capture and result checking
  always @(posedge clk) begin
    comp_res_t e;
    if (!rst_n) begin
      cal_temp <= '0; cal_press_a <= '0; cal_press_b <= '0; cal_press_c <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TEMP:    cal_temp    <= cfg_data[47:0];
          CFG_PRESS_A: cal_press_a <= cfg_data;
          CFG_PRESS_B: cal_press_b <= cfg_data;
          CFG_PRESS_C: cal_press_c <= cfg_data[15:0];
        endcase
      end
      if (start && !busy) comp_queue.push_back(compensate(in_adc_temp, in_adc_press));
      if (out_valid) begin
        if (comp_queue.size() == 0) begin
          $display("%0t: unexpected result temp=%0h fine=%0h press=%0h inv=%0b", $time,
                   out_temp_centi, out_fine_temp, out_press_q24_8, out_press_invalid);
          mismatches++;
        end else begin
          e = comp_queue.pop_front();
          if (out_temp_centi !== e.temp_centi) begin
            $display("%0t: temp_centi expected %0h actual %0h", $time, e.temp_centi,
                     out_temp_centi);
            mismatches++;
          end
          if (out_fine_temp !== e.fine_temp) begin
            $display("%0t: fine_temp expected %0h actual %0h", $time, e.fine_temp,
                     out_fine_temp);
            mismatches++;
          end
          if (out_press_q24_8 !== e.press) begin
            $display("%0t: press_q24_8 expected %0h actual %0h", $time, e.press,
                     out_press_q24_8);
            mismatches++;
          end
          if (out_press_invalid !== e.invalid) begin
            $display("%0t: press_invalid expected %0b actual %0b", $time, e.invalid,
                     out_press_invalid);
            mismatches++;
          end
        end
      end
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [19:0] at, input logic [19:0] ap);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start        <= 1'b1;
    in_adc_temp  <= at;
    in_adc_press <= ap;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (comp_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_cal(input cfg_idx_t idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_cal(input logic [63:0] t, input logic [63:0] pa, input logic [63:0] pb,
                          input logic [63:0] pc);
    wait_drained();
    write_cal(CFG_TEMP, t);
    write_cal(CFG_PRESS_A, pa);
    write_cal(CFG_PRESS_B, pb);
    write_cal(CFG_PRESS_C, pc);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [19:0] corners[5] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'h7EED0};
    // zero calibration: divisor is zero, pressure flagged invalid
    foreach (corners[i]) send_sample(corners[i], corners[4 - i]);
    load_cal(64'hFC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D, 64'hC6F8_3C8C_FFF9_008C,
             64'h1770);
    foreach (corners[i]) send_sample(corners[i], corners[i]);
    send_sample(20'd519888, 20'd415148);
    load_cal('1, '1, '1, '1);
    foreach (corners[i]) send_sample(corners[i], corners[(i + 2) % 5]);
    load_cal(64'h8000_7FFF_FFFF, 64'h7FFF_8000_7FFF_FFFF, 64'h8000_7FFF_8000_7FFF,
             64'hFFFF_FFFF_FFFF_8000);
    foreach (corners[i]) send_sample(corners[i], corners[(i + 1) % 5]);
  endtask

  task automatic test_random(input int pct, input int count);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i % 55 == 0) begin
        if ($urandom_range(1)) load_cal(rand64(), rand64(), rand64(), rand64());
        else load_cal({16'($urandom_range(26000, 29000) - 1500 * $urandom_range(1)),
                       16'($urandom_range(25000, 27000)), 16'($urandom_range(27000, 28500))},
                      {16'($urandom_range(2000, 3500)), 16'($urandom_range(2500, 3500)),
                       16'(-$urandom_range(10000, 11500)), 16'($urandom_range(34000, 38000))},
                      {16'(-$urandom_range(13000, 16000)), 16'($urandom_range(14000, 16000)),
                       16'(-$urandom_range(1, 10)), 16'($urandom_range(100, 200))},
                      64'($urandom_range(4000, 7000)));
      end
      if ($urandom_range(3) == 0) send_sample(20'($urandom), 20'($urandom));
      else send_sample(20'($urandom_range(480000, 560000)), 20'($urandom_range(250000, 450000)));
    end
  endtask

  task automatic test_pause_drain();
    idle_pct = 0;
    repeat (10) send_sample(20'($urandom), 20'($urandom));
    wait_drained();
    repeat (10) send_sample(20'($urandom), 20'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(34, 210);
    test_pause_drain();
    test_random(54, 210);
    test_random(0, 210);
    wait_drained();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
hdl/bptc_pkg.sv
hdl/bptc_temp.sv
hdl/bptc_press_pre.sv
hdl/bptc_div.sv
hdl/bptc_press_post.sv
hdl/baro_temp_press_compensate_top.sv
verif/tb_baro_temp_press_compensate_top.sv
